// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = ROW_W + COL_W;
  localparam int LOC_W  = 11;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic             done;
    logic [ROW_W-1:0] quot;
    logic [COL_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/tcw_screen_ram.sv =====
// Screen cell memory with one write port and one registered read port.
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tcw_row_div.sv =====
// Splits a linear cell index into row and column by reciprocal multiplication.
`default_nettype none

module tcw_row_div #(
  parameter int COLUMNS = 80
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tcw_pkg::LOC_W-1:0] index,
  output tcw_pkg::div_res_t              res
);

  localparam int SH = 18;
  localparam int MW = 16;
  localparam int PW = tcw_pkg::LOC_W + MW;
  localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + COLUMNS - 1) / COLUMNS);

  logic [PW-1:0]             prod;
  logic [tcw_pkg::LOC_W-1:0] row_base;
  logic [tcw_pkg::LOC_W-1:0] diff;
  logic [tcw_pkg::LOC_W-1:0] index_q;
  logic [tcw_pkg::ROW_W-1:0] quot;
  logic [tcw_pkg::COL_W-1:0] rem;
  logic                      busy;
  logic                      done;

  // The quotient is exact for every index below 2048 with an 18-bit shift.
  assign prod     = PW'(index) * PW'(RECIP);
  assign row_base = tcw_pkg::LOC_W'(quot) * tcw_pkg::LOC_W'(COLUMNS);
  assign diff     = index_q - row_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot    <= prod[SH +: tcw_pkg::ROW_W];
        index_q <= index;
        busy    <= 1'b1;
      end else if (busy) begin
        rem  <= diff[tcw_pkg::COL_W-1:0];
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

`default_nettype wire

// ===== design/text_console_writer.sv =====
// Top level of the text console writer: command decode, cursor and screen ring.
//
// Input channel s_*: one transfer carries one command (put, clear or read).
// Output channel m_*: one transfer per command with the cursor location,
// the cell read (read command only) and a scroll flag.
// The block handles one command at a time. A put, clear, unused or
// out-of-range read command is executed in the state after the input
// transfer, which loads its result into the output register; the next command
// is taken once the block is back in idle. An in-range read passes through a
// reciprocal multiplication and a subtraction that split the index into
// row and column, then one memory read and the output register.
// Scrolling moves a top-row pointer over the cell memory and marks the new
// bottom row as stale; clear marks every row stale. The first printable
// write into a stale row first blanks that row, one cell per cycle.
// Reads of a stale row return the blank cell.
// Reset homes the cursor and marks all rows stale, so the screen reads
// blank at once; no clearing pass runs.
// The result sits in an output register; while the receiver stalls, the
// block holds it and takes no new command beyond the one being worked on.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[1:0], char_code[9:2], background[13:10], foreground[17:14],
  // cell_index[28:18], zero fill above.
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cursor_location[10:0], cell_data[26:11], scrolled[27], zero fill above.
  output logic      [31:0] m_tdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = tcw_pkg::ROW_W;
  localparam int CW    = tcw_pkg::COL_W;
  localparam int XW    = tcw_pkg::CELL_W;
  localparam int LW    = tcw_pkg::LOC_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_DIV   = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t          state;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [3:0]      tab_phase;
  logic [RW-1:0]   top_row;
  logic [ROWS-1:0] row_valid;
  logic [CW-1:0]   sweep_col;
  logic            rd_blank;

  logic [1:0]      cmd;
  logic [7:0]      ch;
  logic [7:0]      attr;
  logic [LW-1:0]   idx;

  logic [LW-1:0]   out_loc;
  logic [15:0]     out_data;
  logic            out_scrolled;
  logic            out_load;

  logic            go;
  logic            printable;
  logic [RW-1:0]   cur_phys;
  logic [RW-1:0]   rd_phys;
  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   sweep_addr;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      col_n;
  logic [RW:0]     row_n;
  logic [3:0]      phase_n;
  logic            scroll_n;
  logic [CW-1:0]   col_fin;
  logic [RW-1:0]   row_fin;
  logic [LW-1:0]   loc_fin;
  logic [LW-1:0]   loc_cur;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [15:0]     mem_rdata;

  logic            div_start;
  tcw_pkg::div_res_t div_res;

  function automatic logic [RW-1:0] ring_add(logic [RW-1:0] a, logic [RW-1:0] b);
    logic [RW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [XW-1:0] cell_pos(logic [RW-1:0] r, logic [CW-1:0] c);
    return XW'(r) * XW'(COLUMNS) + XW'(c);
  endfunction

  assign s_tready  = (state == S_IDLE) && !rst;
  assign go        = !m_tvalid || m_tready;
  assign printable = (ch >= tcw_pkg::CH_PRINT_LO) && (ch <= tcw_pkg::CH_PRINT_HI);

  assign cur_phys   = ring_add(top_row, cur_row);
  assign rd_phys    = ring_add(top_row, div_res.quot);
  assign cur_addr   = AW'(cell_pos(cur_phys, cur_col));
  assign sweep_addr = AW'(cell_pos(cur_phys, sweep_col));
  assign rd_addr    = AW'(cell_pos(rd_phys, div_res.rem));
  assign loc_cur    = LW'(cell_pos(cur_row, cur_col));

  always_comb begin
    col_n    = {1'b0, cur_col};
    row_n    = {1'b0, cur_row};
    phase_n  = tab_phase;
    scroll_n = 1'b0;
    case (ch)
      tcw_pkg::CH_BS: begin
        if (cur_col != '0) begin
          col_n   = {1'b0, cur_col} - 8'd1;
          phase_n = (tab_phase == 4'd0) ? 4'(TAB_STEP - 1) : tab_phase - 4'd1;
        end
      end
      tcw_pkg::CH_TAB: begin
        col_n   = {1'b0, cur_col} + 8'(TAB_STEP) - {4'b0, tab_phase};
        phase_n = 4'd0;
      end
      tcw_pkg::CH_CR: begin
        col_n   = 8'd0;
        phase_n = 4'd0;
      end
      tcw_pkg::CH_LF: begin
        col_n   = 8'd0;
        phase_n = 4'd0;
        row_n   = {1'b0, cur_row} + (RW+1)'(1);
      end
      default: begin
        if (printable) begin
          col_n   = {1'b0, cur_col} + 8'd1;
          phase_n = (tab_phase == 4'(TAB_STEP - 1)) ? 4'd0 : tab_phase + 4'd1;
        end
      end
    endcase
    if (col_n >= 8'(COLUMNS)) begin
      col_n   = 8'd0;
      phase_n = 4'd0;
      row_n   = row_n + (RW+1)'(1);
    end
    if (row_n >= (RW+1)'(ROWS)) begin
      row_n    = (RW+1)'(ROWS - 1);
      scroll_n = 1'b1;
    end
    col_fin = col_n[CW-1:0];
    row_fin = row_n[RW-1:0];
    loc_fin = LW'(cell_pos(row_fin, col_fin));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {attr, ch};
    mem_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (cmd == tcw_pkg::CMD_PUT && printable && row_valid[cur_phys] && go) begin
          mem_we = 1'b1;
        end
        if (cmd == tcw_pkg::CMD_READ && idx < LW'(CELLS)) begin
          div_start = 1'b1;
        end
        out_load = go && !(cmd == tcw_pkg::CMD_PUT && printable && !row_valid[cur_phys])
                   && !(cmd == tcw_pkg::CMD_READ && idx < LW'(CELLS));
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = tcw_pkg::BLANK_CELL;
      end
      S_DIV: begin
        mem_re = div_res.done;
      end
      S_READ: begin
        out_load = go;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_col   <= '0;
      cur_row   <= '0;
      tab_phase <= '0;
      top_row   <= '0;
      row_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tdata[1:0];
            ch    <= s_tdata[9:2];
            attr  <= {s_tdata[13:10], s_tdata[17:14]};
            idx   <= s_tdata[28:18];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd == tcw_pkg::CMD_PUT && printable && !row_valid[cur_phys]) begin
            sweep_col <= '0;
            state     <= S_SWEEP;
          end else if (cmd == tcw_pkg::CMD_READ && idx < LW'(CELLS)) begin
            state <= S_DIV;
          end else if (go) begin
            out_data <= '0;
            if (cmd == tcw_pkg::CMD_PUT) begin
              cur_col      <= col_fin;
              cur_row      <= row_fin;
              tab_phase    <= phase_n;
              out_loc      <= loc_fin;
              out_scrolled <= scroll_n;
              if (scroll_n) begin
                top_row            <= ring_add(top_row, RW'(1));
                row_valid[top_row] <= 1'b0;
              end
            end else if (cmd == tcw_pkg::CMD_CLEAR) begin
              cur_col      <= '0;
              cur_row      <= '0;
              tab_phase    <= '0;
              row_valid    <= '0;
              out_loc      <= '0;
              out_scrolled <= 1'b0;
            end else begin
              out_loc      <= loc_cur;
              out_scrolled <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          sweep_col <= sweep_col + CW'(1);
          if (sweep_col == CW'(COLUMNS - 1)) begin
            row_valid[cur_phys] <= 1'b1;
            state               <= S_EXEC;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            rd_blank <= !row_valid[rd_phys];
            state    <= S_READ;
          end
        end
        S_READ: begin
          if (go) begin
            out_loc      <= loc_cur;
            out_data     <= rd_blank ? tcw_pkg::BLANK_CELL : mem_rdata;
            out_scrolled <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'b0, out_scrolled, out_data, out_loc};

  tcw_screen_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  tcw_row_div #(
    .COLUMNS(COLUMNS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .index(idx),
    .res  (div_res)
  );

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col < CW'(COLUMNS)) && (cur_row < RW'(ROWS)))
    else $error("cursor outside the screen");

  a_tab_phase: assert property (@(posedge clk) disable iff (rst)
    (32'(tab_phase) < TAB_STEP) && (32'(tab_phase) == 32'(cur_col) % TAB_STEP))
    else $error("tab phase out of step with cursor column");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted command not taken into execution");

  a_div_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_res.done) |=> (state == S_READ))
    else $error("divider result did not start the cell read");

  a_sweep_blank: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (mem_we && mem_wdata == tcw_pkg::BLANK_CELL))
    else $error("row blanking wrote a non-blank cell");
`endif

endmodule

`default_nettype wire
